// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file (lfc_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while arst_n is low.
`define LFC_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("list fold calculator check failed");

// Antecedent in this cycle, consequent in the next.
`define LFC_ASSERT_NEXT(name, ante, cons) `LFC_ASSERT(name, (ante) |=> (cons))

`endif

// File: rtl/lfc_pkg.sv
package lfc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int OP_WIDTH   = 3;

	localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
	localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
	localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
	localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
	localparam logic [OP_WIDTH-1:0] OP_GCD = 3'd4;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         first;
		logic                         last;
	} operand_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result;
		logic                         div_zero_error;
	} result_t;

	typedef struct packed {
		logic accept;
		logic load_first;
		logic add;
		logic sub;
		logic mul;
		logic mul_wb;
		logic set_err;
		logic div_start;
		logic div_wb;
		logic gcd_step;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic                first;
		logic                last;
		logic                err;
		logic [OP_WIDTH-1:0] op;
		logic                v_zero;
		logic                v_pos;
		logic                div_done;
		logic                out_free;
	} dp_status_t;

endpackage

// File: rtl/lfc_divider.sv
module lfc_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lfc_pkg::DATA_WIDTH-1:0]    dividend,
	input  logic [lfc_pkg::DATA_WIDTH-1:0]    divisor,
	output logic                              done,
	output logic [lfc_pkg::DATA_WIDTH-1:0]    quotient,
	output logic [lfc_pkg::DATA_WIDTH-1:0]    remainder
);

	localparam int DW = lfc_pkg::DATA_WIDTH;
	localparam int CW = $clog2(DW);

	logic [DW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          qneg_q;
	logic          rneg_q;

	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic [DW-1:0] mag_a;
	logic [DW-1:0] mag_b;

	assign mag_a   = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b   = divisor[DW-1]  ? (~divisor + 1'b1)  : divisor;
	assign shifted = {rem_q, num_q[DW-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= mag_a;
			den_q  <= mag_b;
			rem_q  <= '0;
			qneg_q <= dividend[DW-1] ^ divisor[DW-1];
			rneg_q <= dividend[DW-1];
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				num_q <= {num_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				num_q <= {num_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = qneg_q ? (~num_q + 1'b1) : num_q;
	assign remainder = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

// File: rtl/lfc_datapath.sv
module lfc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              operand_valid,
	input  lfc_pkg::operand_t                 operand,
	input  logic                              cfg_we,
	input  logic [lfc_pkg::OP_WIDTH-1:0]      cfg_data,
	input  logic                              result_stall,
	input  lfc_pkg::ctrl_cmd_t                cmd,
	output lfc_pkg::dp_status_t               status,
	output logic                              result_valid,
	output lfc_pkg::result_t                  result_item
);

	localparam int DW = lfc_pkg::DATA_WIDTH;

	logic [lfc_pkg::OP_WIDTH-1:0] op_q;
	logic [DW-1:0]                acc_q;
	logic                         err_q;
	logic [DW-1:0]                v_q;
	logic                         first_q;
	logic                         last_q;
	logic [DW-1:0]                prod_s1;
	logic                         out_valid_q;
	lfc_pkg::result_t             out_q;

	logic [DW-1:0]   mul_lo;
	logic            div_done;
	logic [DW-1:0]   quo;
	logic [DW-1:0]   rem;

	assign mul_lo = acc_q * v_q;

	lfc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (acc_q),
		.divisor   (v_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= lfc_pkg::OP_ADD;
			acc_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				op_q <= cfg_data;
			end
			if (cmd.load_first) begin
				acc_q <= v_q;
				err_q <= 1'b0;
			end else if (cmd.add) begin
				acc_q <= acc_q + v_q;
			end else if (cmd.sub) begin
				acc_q <= acc_q - v_q;
			end else if (cmd.mul_wb) begin
				acc_q <= prod_s1;
			end else if (cmd.div_wb) begin
				acc_q <= quo;
			end else if (cmd.gcd_step) begin
				acc_q <= v_q;
			end
			if (cmd.set_err) begin
				err_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && operand_valid) begin
			v_q     <= operand.value;
			first_q <= operand.first;
			last_q  <= operand.last;
		end else if (cmd.gcd_step) begin
			v_q <= rem;
		end
		if (cmd.mul) begin
			prod_s1 <= mul_lo;
		end
		if (cmd.emit) begin
			out_q.result         <= err_q ? '0 : acc_q;
			out_q.div_zero_error <= err_q;
		end
	end

	always_comb begin
		status.first    = first_q;
		status.last     = last_q;
		status.err      = err_q;
		status.op       = op_q;
		status.v_zero   = (v_q == '0);
		status.v_pos    = (v_q != '0) && !v_q[DW-1];
		status.div_done = div_done;
		status.out_free = !out_valid_q || !result_stall;
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

endmodule

// File: rtl/lfc_ctrl.sv
module lfc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 operand_valid,
	input  lfc_pkg::dp_status_t  status,
	output lfc_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_MUL,
		S_DIV,
		S_GCD,
		S_GCD_CHK,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = 1'b1;
				if (operand_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_FIN;
				if (status.first) begin
					cmd.load_first = 1'b1;
				end else if (!status.err) begin
					case (status.op)
						lfc_pkg::OP_ADD: cmd.add = 1'b1;
						lfc_pkg::OP_SUB: cmd.sub = 1'b1;
						lfc_pkg::OP_MUL: begin
							cmd.mul = 1'b1;
							state_d = S_MUL;
						end
						lfc_pkg::OP_DIV: begin
							if (status.v_zero) begin
								cmd.set_err = 1'b1;
							end else begin
								cmd.div_start = 1'b1;
								state_d = S_DIV;
							end
						end
						lfc_pkg::OP_GCD: begin
							if (status.v_pos) begin
								cmd.div_start = 1'b1;
								state_d = S_GCD;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_MUL: begin
				cmd.mul_wb = 1'b1;
				state_d = S_FIN;
			end
			S_DIV: begin
				if (status.div_done) begin
					cmd.div_wb = 1'b1;
					state_d = S_FIN;
				end
			end
			S_GCD: begin
				if (status.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d = S_GCD_CHK;
				end
			end
			S_GCD_CHK: begin
				// loop while the new divisor is positive
				if (status.v_pos) begin
					cmd.div_start = 1'b1;
					state_d = S_GCD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!status.last) begin
					state_d = S_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/list_fold_calculator_top.sv
// List fold calculator: folds a list of signed 32-bit numbers with one operation.
// operand channel (operand_valid / operand_stall / operand): one number per item,
//   with first marking the item that loads the accumulator and last marking the
//   item after which the result is sent.
// result channel (result_valid / result_stall / result_item): one item per list,
//   carrying the final value, or zero with div_zero_error set.
// cfg channel (cfg_valid / cfg_ready / cfg_data): selects the operation; write it
//   only while no list item is being worked on. cfg_ready is always high.
// One item is worked on at a time: IDLE accepts it, then DECIDE and FIN for an add,
//   subtract, load or ignored item; a multiply adds MUL, a divide adds DIV while the
//   shared divider makes one quotient bit per cycle, and GCD passes GCD and GCD_CHK
//   once per remainder step. A result enters the output register as FIN is left; a
//   new item may be taken while it waits there.
// If the receiver stalls, the result holds and a second finished list waits in
//   the block, with operand_stall high, until the output register frees.
// Reset clears the accumulator, error flag, operation (add) and the result valid.
module list_fold_calculator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          operand_valid,
	output logic                          operand_stall,
	input  lfc_pkg::operand_t             operand,
	output logic                          result_valid,
	input  logic                          result_stall,
	output lfc_pkg::result_t              result_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfc_pkg::OP_WIDTH-1:0]  cfg_data
);

	lfc_pkg::ctrl_cmd_t  cmd;
	lfc_pkg::dp_status_t status;

	assign cfg_ready     = 1'b1;
	assign operand_stall = !cmd.accept;

	lfc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.status        (status),
		.cmd           (cmd)
	);

	lfc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand       (operand),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.result_stall  (result_stall),
		.cmd           (cmd),
		.status        (status),
		.result_valid  (result_valid),
		.result_item   (result_item)
	);

endmodule

// File: rtl/lfc_checker.sv
`include "assert_macros.svh"

module lfc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          operand_valid,
	input logic                          operand_stall,
	input lfc_pkg::operand_t             operand,
	input logic                          result_valid,
	input logic                          result_stall,
	input lfc_pkg::result_t              result_item,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [lfc_pkg::OP_WIDTH-1:0]  cfg_data
);

	`LFC_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid)
	`LFC_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result_item))
	`LFC_ASSERT(a_err_zero, result_valid && result_item.div_zero_error |-> result_item.result == '0)
	`LFC_ASSERT_NEXT(a_busy_after_take, operand_valid && !operand_stall, operand_stall)

endmodule

bind list_fold_calculator_top lfc_checker u_lfc_checker (.*);

// File: sim/testbench.sv
module testbench;

	localparam int SETTLE_CYCLES = 1700;	// worst GCD fold of one item, plus margin
	localparam int CYCLE_LIMIT   = 20_000_000;
	localparam int HOLD_CYCLES   = 600;
	localparam int PHASE_ITEMS   = 150;
	localparam int DW            = lfc_pkg::DATA_WIDTH;
	localparam int OW            = lfc_pkg::OP_WIDTH;

	localparam logic [OW-1:0] OP_UNUSED5 = 3'd5;
	localparam logic [OW-1:0] OP_UNUSED6 = 3'd6;
	localparam logic [OW-1:0] OP_UNUSED7 = 3'd7;

	localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                operand_valid = 1'b0;
	logic                operand_stall;
	lfc_pkg::operand_t   operand       = '0;
	logic                result_valid;
	logic                result_stall  = 1'b0;
	lfc_pkg::result_t    result_item;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [OW-1:0]       cfg_data      = '0;

	list_fold_calculator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_stall (operand_stall),
		.operand       (operand),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_item   (result_item),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	lfc_pkg::operand_t operands_to_send[$];
	lfc_pkg::result_t  lists_due[$];

	logic [OW-1:0] fold_op  = lfc_pkg::OP_ADD;
	logic [DW-1:0] fold_acc = '0;
	logic          fold_err = 1'b0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int recv_hold_left = 0;
	int hold_requests  = 0;
	int holds_started  = 0;
	int operands_sent  = 0;
	int lists_checked  = 0;
	int zero_div_lists = 0;
	int mismatches     = 0;
	int settings_used  = 1;

	lfc_pkg::result_t got, want;

	function automatic logic [DW-1:0] magnitude_of(input logic [DW-1:0] x);
		return x[DW-1] ? -x : x;
	endfunction

	function automatic logic [DW-1:0] trunc_quotient(input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		logic [DW-1:0] q;
		q = magnitude_of(a) / magnitude_of(b);
		return (a[DW-1] ^ b[DW-1]) ? -q : q;
	endfunction

	function automatic logic [DW-1:0] trunc_remainder(input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		logic [DW-1:0] r;
		r = magnitude_of(a) % magnitude_of(b);
		return a[DW-1] ? -r : r;
	endfunction

	// Euclid, runs only while the divisor is positive
	function automatic logic [DW-1:0] gcd_fold(input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		logic [DW-1:0] r;
		while (b != '0 && !b[DW-1]) begin
			r = trunc_remainder(a, b);
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic void fold_operand(input lfc_pkg::operand_t item);
		logic [DW-1:0]    v;
		lfc_pkg::result_t r;
		v = item.value;
		if (item.first) begin
			fold_acc = v;
			fold_err = 1'b0;
		end else if (!fold_err) begin
			case (fold_op)
				lfc_pkg::OP_ADD: fold_acc = fold_acc + v;
				lfc_pkg::OP_SUB: fold_acc = fold_acc - v;
				lfc_pkg::OP_MUL: fold_acc = fold_acc * v;
				lfc_pkg::OP_DIV: begin
					if (v == '0)
						fold_err = 1'b1;
					else
						fold_acc = trunc_quotient(fold_acc, v);
				end
				lfc_pkg::OP_GCD: fold_acc = gcd_fold(fold_acc, v);
				default: ;
			endcase
		end
		if (item.last) begin
			r.result         = fold_err ? '0 : fold_acc;
			r.div_zero_error = fold_err;
			lists_due.push_back(r);
		end
	endfunction

	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return '0;
					3: return '1;
					default: return 1;
				endcase
			end
			1, 2, 3: return $urandom_range(40) - 20;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [OW-1:0] op_for_phase(input int p);
		case (p)
			0: return lfc_pkg::OP_ADD;
			1: return lfc_pkg::OP_SUB;
			2: return lfc_pkg::OP_MUL;
			3: return lfc_pkg::OP_DIV;
			4: return lfc_pkg::OP_GCD;
			5: return OP_UNUSED5;
			6: return lfc_pkg::OP_DIV;
			7: return OP_UNUSED7;
			8: return lfc_pkg::OP_GCD;
			9: return OP_UNUSED6;
			10: return lfc_pkg::OP_MUL;
			default: return lfc_pkg::OP_ADD;
		endcase
	endfunction

	task automatic queue_operand(input logic [DW-1:0] v, input logic first,
			input logic last);
		lfc_pkg::operand_t item;
		item.value = v;
		item.first = first;
		item.last  = last;
		operands_to_send.push_back(item);
	endtask

	// mostly well-formed lists; about one draw in ten queues a single item with random marks
	task automatic queue_random_lists(input int count, input int max_len);
		int n;
		int len;
		n = 0;
		while (n < count) begin
			if ($urandom_range(9) == 0) begin
				queue_operand(pick_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
				n++;
			end else begin
				len = $urandom_range(1, max_len);
				for (int i = 0; i < len; i++)
					queue_operand(pick_value(), i == 0, i == len - 1);
				n += len;
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (operands_to_send.size() != 0 || operand_valid || lists_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_operation(input logic [OW-1:0] op);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= op;
		do @(posedge clk);
		while (!cfg_ready);
		fold_op = op;
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (operand_valid && !operand_stall) begin
				fold_operand(operands_to_send.pop_front());
				operands_sent++;
			end
			if (!operand_valid || !operand_stall) begin
				if (operands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					operand_valid <= 1'b1;
					operand       <= operands_to_send[0];
				end else begin
					operand_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (recv_hold_left != 0) begin
			recv_hold_left <= recv_hold_left - 1;
		end else if (holds_started != hold_requests) begin
			recv_hold_left <= HOLD_CYCLES;
			holds_started  <= holds_started + 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got = result_item;
				if (lists_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with none pending: expected none, got %0d err %b",
						$time, got.result, got.div_zero_error);
				end else begin
					want = lists_due.pop_front();
					lists_checked++;
					if (want.div_zero_error)
						zero_div_lists++;
					if (got.result !== want.result) begin
						mismatches++;
						$display("%0t: result value: expected %0d, got %0d",
							$time, want.result, got.result);
					end
					if (got.div_zero_error !== want.div_zero_error) begin
						mismatches++;
						$display("%0t: div_zero_error: expected %b, got %b",
							$time, want.div_zero_error, got.div_zero_error);
					end
				end
			end
			result_stall <= recv_hold_left != 0 || $urandom_range(99) < recv_stall_pct;
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// add from reset, no first item yet
		queue_operand(5, 1'b0, 1'b1);
		queue_operand(MOST_POS, 1'b1, 1'b1);
		queue_operand(MOST_POS, 1'b1, 1'b0);
		queue_operand(1, 1'b0, 1'b1);
		set_operation(lfc_pkg::OP_SUB);
		queue_operand(MOST_NEG, 1'b1, 1'b0);
		queue_operand(1, 1'b0, 1'b1);
		set_operation(lfc_pkg::OP_MUL);
		queue_operand(32'h0001_0000, 1'b1, 1'b0);
		queue_operand(32'h0001_0000, 1'b0, 1'b1);
		queue_operand(-1, 1'b1, 1'b0);
		queue_operand(MOST_NEG, 1'b0, 1'b1);
		set_operation(lfc_pkg::OP_DIV);
		queue_operand(MOST_NEG, 1'b1, 1'b0);
		queue_operand(-1, 1'b0, 1'b1);
		queue_operand(7, 1'b1, 1'b0);
		queue_operand(-2, 1'b0, 1'b1);
		queue_operand(5, 1'b1, 1'b0);
		queue_operand(0, 1'b0, 1'b0);
		queue_operand(3, 1'b0, 1'b1);
		queue_operand(-7, 1'b1, 1'b0);
		queue_operand(2, 1'b0, 1'b1);
		set_operation(lfc_pkg::OP_GCD);
		queue_operand(48, 1'b1, 1'b0);
		queue_operand(18, 1'b0, 1'b1);
		queue_operand(48, 1'b1, 1'b0);
		queue_operand(-6, 1'b0, 1'b0);
		queue_operand(0, 1'b0, 1'b1);
		queue_operand(-48, 1'b1, 1'b0);
		queue_operand(18, 1'b0, 1'b1);
		set_operation(OP_UNUSED7);
		queue_operand(9, 1'b1, 1'b0);
		queue_operand(4, 1'b0, 1'b1);

		// receiver holds off while short lists keep coming
		set_operation(lfc_pkg::OP_ADD);
		for (int i = 0; i < 40; i++) begin
			len = $urandom_range(1, 2);
			for (int j = 0; j < len; j++)
				queue_operand(pick_value(), j == 0, j == len - 1);
		end
		@(posedge clk);
		hold_requests <= hold_requests + 1;

		for (int p = 0; p < 12; p++) begin
			set_operation(op_for_phase(p));
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 71;
				end
				default: begin
					send_idle_pct  = 16;
					recv_stall_pct = 16;
				end
			endcase
			queue_random_lists(PHASE_ITEMS, 5);
		end
		wait_idle();

		$display("%0d operands folded under %0d operation settings, %0d lists checked",
			operands_sent, settings_used, lists_checked);
		$display("%0d lists ended on a zero divisor, %0d mismatches",
			zero_div_lists, mismatches);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
